FILE: sv/bcc_pkg.sv
// bcc_pkg: shared types and constants of the button click classifier
// depends on nothing; used by the interfaces and every module of the block
package bcc_pkg;

  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 3;

  localparam logic [TIME_W-1:0] EVENT_LIFETIME = TIME_W'(500);

  // event and take request codes
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_PRESSED  = 3'd1;
  localparam logic [2:0] EV_RELEASED = 3'd2;
  localparam logic [2:0] EV_MULTI    = 3'd3;
  localparam logic [2:0] EV_LONG     = 3'd4;
  localparam logic [2:0] REQ_ANY     = 3'd5;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [IDX_W-1:0] REG_DEBOUNCE    = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAP         = 3'd2;
  localparam logic [IDX_W-1:0] REG_LONG_HOLD   = 3'd3;
  localparam logic [IDX_W-1:0] REG_SLOW        = 3'd4;
  localparam logic [IDX_W-1:0] REG_FAST        = 3'd5;
  localparam logic [IDX_W-1:0] REG_RAMP_START  = 3'd6;
  localparam logic [IDX_W-1:0] REG_RAMP_END    = 3'd7;

  typedef struct packed {
    logic        enable;
    logic [7:0]  debounce_time;
    logic [15:0] multiclick_gap;
    logic [15:0] long_hold_time;
    logic [15:0] repeat_slow_interval;
    logic [15:0] repeat_fast_interval;
    logic [15:0] repeat_ramp_start;
    logic [15:0] repeat_ramp_end;
  } cfg_t;

  // event report of one word, already zeroed when disabled
  typedef struct packed {
    logic [2:0] code;
    logic       taken;
    logic [7:0] clicks;
  } ev_res_t;

endpackage

FILE: sv/bcc_if.sv
// bcc_if: handshake channels of the button click classifier
// depends on bcc_pkg for field widths
interface bcc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      raw_level;
  logic [bcc_pkg::TIME_W-1:0] now;
  logic [2:0]                action;
  modport source (output valid, output raw_level, output now, output action, input ready);
  modport sink   (input valid, input raw_level, input now, input action, output ready);
endinterface

interface bcc_out_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                event_code;
  logic                      event_taken;
  logic [7:0]                burst_clicks;
  logic                      stable_pressed;
  logic [bcc_pkg::TIME_W-1:0] hold_duration;
  logic                      repeat_pulse;
  modport source (output valid, output event_code, output event_taken, output burst_clicks,
                  output stable_pressed, output hold_duration, output repeat_pulse,
                  input ready);
  modport sink   (input valid, input event_code, input event_taken, input burst_clicks,
                  input stable_pressed, input hold_duration, input repeat_pulse,
                  output ready);
endinterface

interface bcc_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [bcc_pkg::IDX_W-1:0] index;
  logic [bcc_pkg::CFG_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/bcc_div.sv
// bcc_div: serial restoring divider, one quotient bit per cycle
// depends on bcc_pkg for the time width
module bcc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bcc_pkg::TIME_W-1:0] dividend,
  input  logic [15:0]                divisor,
  output logic                       done,
  output logic [bcc_pkg::TIME_W-1:0] quotient
);

  localparam int CNT_W = $clog2(bcc_pkg::TIME_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [15:0]      rem;
  logic [15:0]      dvs;
  logic [16:0]      shifted;
  logic [16:0]      trial;

  assign shifted = {rem, quotient[bcc_pkg::TIME_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        // trial subtract, keep it when no borrow
        if (!trial[16]) begin
          rem      <= trial[15:0];
          quotient <= {quotient[bcc_pkg::TIME_W-2:0], 1'b1};
        end else begin
          rem      <= shifted[15:0];
          quotient <= {quotient[bcc_pkg::TIME_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(bcc_pkg::TIME_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/bcc_event.sv
// bcc_event: debounce, click and long hold event latch, take request
// depends on bcc_pkg for codes, config struct and event report struct
module bcc_event (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic                       level,
  input  logic [bcc_pkg::TIME_W-1:0] now,
  input  logic [2:0]                 action,
  input  bcc_pkg::cfg_t              cfg,
  output bcc_pkg::ev_res_t           res,
  output logic                       stable_level,
  output logic [bcc_pkg::TIME_W-1:0] press_time
);

  localparam int TW = bcc_pkg::TIME_W;

  logic          raw_previous;
  logic [TW-1:0] raw_change_time;
  logic [TW-1:0] stable_change_time;
  logic [TW-1:0] event_time;
  logic [2:0]    pending_event;
  logic [7:0]    press_counter;
  logic [7:0]    reported_clicks;
  logic          long_lock;

  logic [TW-1:0] raw_change_time_next;
  logic          stable_level_next;
  logic [TW-1:0] stable_change_time_next;
  logic [TW-1:0] press_time_next;
  logic [TW-1:0] event_time_next;
  logic [2:0]    pending_event_next;
  logic [7:0]    press_counter_next;
  logic [7:0]    reported_clicks_next;
  logic          long_lock_next;
  bcc_pkg::ev_res_t res_next;

  logic deb_ok, gap_ok, long_ok, stamp, expire;
  logic [TW-1:0] since_stable;
  logic [TW-1:0] since_event;

  assign since_stable = now - stable_change_time;
  assign since_event  = now - event_time;

  always_comb begin
    raw_change_time_next    = (level != raw_previous) ? now : raw_change_time;
    stable_level_next       = stable_level;
    stable_change_time_next = stable_change_time;
    press_time_next         = press_time;
    event_time_next         = event_time;
    pending_event_next      = pending_event;
    press_counter_next      = press_counter;
    reported_clicks_next    = reported_clicks;
    long_lock_next          = long_lock;
    res_next                = '0;
    stamp                   = 1'b0;

    deb_ok  = ((now - raw_change_time_next) > TW'(cfg.debounce_time))
              && (stable_level != level);
    gap_ok  = (since_stable > TW'(cfg.multiclick_gap)) && !stable_level;
    long_ok = (since_stable > TW'(cfg.long_hold_time)) && stable_level
              && (since_event > bcc_pkg::EVENT_LIFETIME) && !long_lock;

    if (deb_ok) begin
      stable_level_next       = level;
      stable_change_time_next = now;
      stamp                   = 1'b1;
      if (level) begin
        press_counter_next = press_counter + 8'd1;
        pending_event_next = bcc_pkg::EV_PRESSED;
        press_time_next    = now;
      end else begin
        pending_event_next = bcc_pkg::EV_RELEASED;
        long_lock_next     = 1'b0;
      end
    end else if (gap_ok) begin
      // burst closed, only two or more presses count as multi-click
      if (press_counter > 8'd1) begin
        reported_clicks_next = press_counter;
        pending_event_next   = bcc_pkg::EV_MULTI;
        stamp                = 1'b1;
      end
      press_counter_next = '0;
    end else if (long_ok) begin
      pending_event_next = bcc_pkg::EV_LONG;
      stamp              = 1'b1;
      press_counter_next = '0;
      long_lock_next     = 1'b1;
    end

    if (stamp) begin
      event_time_next = now;
    end

    // a fresh stamp is never stale
    expire = !stamp && (since_event > bcc_pkg::EVENT_LIFETIME);
    if (expire) begin
      pending_event_next   = bcc_pkg::EV_NONE;
      reported_clicks_next = '0;
    end

    if (cfg.enable) begin
      res_next.code   = pending_event_next;
      res_next.clicks = (pending_event_next == bcc_pkg::EV_MULTI) ? reported_clicks_next : '0;
      if ((pending_event_next != bcc_pkg::EV_NONE) && (action != bcc_pkg::EV_NONE)
          && ((action == pending_event_next) || (action == bcc_pkg::REQ_ANY))) begin
        res_next.taken = 1'b1;
        if (pending_event_next == bcc_pkg::EV_MULTI) begin
          reported_clicks_next = '0;
        end
        pending_event_next = bcc_pkg::EV_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_previous       <= 1'b0;
      raw_change_time    <= '0;
      stable_level       <= 1'b0;
      stable_change_time <= '0;
      press_time         <= '0;
      event_time         <= '0;
      pending_event      <= bcc_pkg::EV_NONE;
      press_counter      <= '0;
      reported_clicks    <= '0;
      long_lock          <= 1'b0;
      res                <= '0;
    end else if (step) begin
      raw_previous       <= level;
      raw_change_time    <= raw_change_time_next;
      stable_level       <= stable_level_next;
      stable_change_time <= stable_change_time_next;
      press_time         <= press_time_next;
      event_time         <= event_time_next;
      pending_event      <= pending_event_next;
      press_counter      <= press_counter_next;
      reported_clicks    <= reported_clicks_next;
      long_lock          <= long_lock_next;
      res                <= res_next;
    end
  end

endmodule

FILE: sv/button_click_classifier_unit.sv
// button_click_classifier_unit: top level of the button click classifier
// depends on bcc_pkg, bcc_if, bcc_event and bcc_div
//
// usage
//   item   : one word per tick with raw_level, now and action (take request)
//   result : one word per item with event_code, event_taken, burst_clicks,
//            stable_pressed, hold_duration and repeat_pulse
//   cfg    : register writes (index, data), always ready; write only when idle (unchecked)
// sequence
//   an item is taken only in the idle state; inside the repeat ramp the word goes through
//   event latch, hold time, ramp setup, one 16x16 multiply, the serial divider (one
//   quotient bit per cycle) and the repeat compare; outside the ramp the multiply and
//   divider are skipped, and when released or disabled the compare is skipped as well;
//   the next item is taken only after the result word is loaded
// reset: synchronous, clears latch and sequencer state and loads the default registers
//   (enable 1, debounce 20, gap 400, long hold 1000, slow 400, fast 50, ramp 1000..3000)
// stall
//   the result word sits in an output register; the next item is taken
//   while it waits, and only the final load waits for the receiver
module button_click_classifier_unit (
  input  logic      clk,
  input  logic      rst,
  bcc_in_if.sink    item,
  bcc_out_if.source result,
  bcc_cfg_if.sink   cfg
);

  localparam int TW = bcc_pkg::TIME_W;

  typedef enum logic [2:0] {
    S_IDLE, S_LATCH, S_HOLD, S_SETUP, S_MULT, S_DIVIDE, S_COMPARE, S_FINISH
  } state_t;

  state_t state;

  // configuration registers
  bcc_pkg::cfg_t regs;

  // captured input word
  logic          level_r;
  logic [TW-1:0] now_r;
  logic [2:0]    action_r;

  // repeat datapath
  logic [TW-1:0] held;
  logic [15:0]   offset;
  logic [15:0]   ivl;
  logic [TW-1:0] repeat_time;
  logic          pulse;

  // output register
  logic          out_valid;
  logic [2:0]    out_code;
  logic          out_taken;
  logic [7:0]    out_clicks;
  logic          out_pressed;
  logic [TW-1:0] out_hold;
  logic          out_pulse;

  // event latch results
  bcc_pkg::ev_res_t ev_res;
  logic             stable_level;
  logic [TW-1:0]    press_time;

  // slope of the ramp as sign and magnitude
  logic          delta_neg;
  logic [15:0]   delta_mag;
  logic [TW-1:0] product;
  logic          div_done;
  logic [TW-1:0] quotient;

  assign delta_neg = regs.repeat_fast_interval < regs.repeat_slow_interval;
  assign delta_mag = delta_neg ? (regs.repeat_slow_interval - regs.repeat_fast_interval)
                               : (regs.repeat_fast_interval - regs.repeat_slow_interval);
  assign product   = TW'(offset) * TW'(delta_mag);

  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;

  assign result.valid          = out_valid;
  assign result.event_code     = out_code;
  assign result.event_taken    = out_taken;
  assign result.burst_clicks   = out_clicks;
  assign result.stable_pressed = out_pressed;
  assign result.hold_duration  = out_hold;
  assign result.repeat_pulse   = out_pulse;

  bcc_event u_event (
    .clk          (clk),
    .rst          (rst),
    .step         (state == S_LATCH),
    .level        (level_r),
    .now          (now_r),
    .action       (action_r),
    .cfg          (regs),
    .res          (ev_res),
    .stable_level (stable_level),
    .press_time   (press_time)
  );

  // divider: |held - start| * |delta| / span, truncated toward zero
  bcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_MULT),
    .dividend (product),
    .divisor  (regs.repeat_ramp_end - regs.repeat_ramp_start),
    .done     (div_done),
    .quotient (quotient)
  );

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.enable               <= 1'b1;
      regs.debounce_time        <= 8'd20;
      regs.multiclick_gap       <= 16'd400;
      regs.long_hold_time       <= 16'd1000;
      regs.repeat_slow_interval <= 16'd400;
      regs.repeat_fast_interval <= 16'd50;
      regs.repeat_ramp_start    <= 16'd1000;
      regs.repeat_ramp_end      <= 16'd3000;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        bcc_pkg::REG_ENABLE:     regs.enable               <= cfg.data[0];
        bcc_pkg::REG_DEBOUNCE:   regs.debounce_time        <= cfg.data[7:0];
        bcc_pkg::REG_GAP:        regs.multiclick_gap       <= cfg.data;
        bcc_pkg::REG_LONG_HOLD:  regs.long_hold_time       <= cfg.data;
        bcc_pkg::REG_SLOW:       regs.repeat_slow_interval <= cfg.data;
        bcc_pkg::REG_FAST:       regs.repeat_fast_interval <= cfg.data;
        bcc_pkg::REG_RAMP_START: regs.repeat_ramp_start    <= cfg.data;
        bcc_pkg::REG_RAMP_END:   regs.repeat_ramp_end      <= cfg.data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      repeat_time <= '0;
      pulse       <= 1'b0;
    end else begin
      // a load in the finish state refills the register in the same edge
      if (out_valid && result.ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            level_r  <= item.raw_level;
            now_r    <= item.now;
            action_r <= item.action;
            state    <= S_LATCH;
          end
        end
        // event latch updates on this edge
        S_LATCH: begin
          state <= S_HOLD;
        end
        S_HOLD: begin
          held  <= now_r - press_time;
          state <= S_SETUP;
        end
        // pick the interval: flat regions need no division
        S_SETUP: begin
          pulse <= 1'b0;
          if (!regs.enable) begin
            state <= S_FINISH;
          end else if (!stable_level) begin
            repeat_time <= '0;
            state       <= S_FINISH;
          end else if (held < TW'(regs.repeat_ramp_start)) begin
            ivl   <= regs.repeat_slow_interval;
            state <= S_COMPARE;
          end else if (held > TW'(regs.repeat_ramp_end)) begin
            ivl   <= regs.repeat_fast_interval;
            state <= S_COMPARE;
          end else if (regs.repeat_ramp_end == regs.repeat_ramp_start) begin
            ivl   <= regs.repeat_slow_interval;
            state <= S_COMPARE;
          end else begin
            // inside the ramp, so held fits 16 bits
            offset <= held[15:0] - regs.repeat_ramp_start;
            state  <= S_MULT;
          end
        end
        S_MULT: begin
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (div_done) begin
            ivl   <= delta_neg ? (regs.repeat_slow_interval - quotient[15:0])
                               : (regs.repeat_slow_interval + quotient[15:0]);
            state <= S_COMPARE;
          end
        end
        S_COMPARE: begin
          if ((now_r - repeat_time) > TW'(ivl)) begin
            repeat_time <= now_r;
            pulse       <= 1'b1;
          end
          state <= S_FINISH;
        end
        // wait for a free output register
        S_FINISH: begin
          if (!out_valid || result.ready) begin
            out_valid   <= 1'b1;
            out_code    <= ev_res.code;
            out_taken   <= ev_res.taken;
            out_clicks  <= ev_res.clicks;
            out_pressed <= regs.enable & stable_level;
            out_hold    <= regs.enable ? held : '0;
            out_pulse   <= pulse;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
